// ===== sv/mpff_pkg.sv =====
// mpff_pkg: shared constants and codes for the monochrome page framebuffer fill block
// no dependencies; imported by mono_page_framebuffer_fill
`default_nettype none

package mpff_pkg;

    // default geometry of the display store
    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 4;

    // pixel rows held in one page byte
    localparam int PAGE_ROWS = 8;

    // command codes
    typedef enum logic [2:0] {
        OP_RECT  = 3'd0,
        OP_VLINE = 3'd1,
        OP_HLINE = 3'd2,
        OP_CLEAR = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    // pixel update codes
    typedef enum logic [1:0] {
        MODE_SET    = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_INVERT = 2'd2
    } mode_t;

endpackage

`default_nettype wire

// ===== sv/mono_page_framebuffer_fill.sv =====
// mono_page_framebuffer_fill: page-organized monochrome display store with fill commands
// depends on mpff_pkg for default geometry, command and mode codes
`default_nettype none

// The store holds PAGES pages of COLUMNS bytes in one synchronous RAM; bit y%8 of byte
// [y/8][x] is pixel (x, y). Rectangle and thick-line commands sweep every byte of the
// store once as a read-modify-write, one byte per cycle, and clear all writes zeros over
// the whole store; each then waits in S_FLUSH until the output register is free, and
// out_valid rises in the same cycle that the next command can be taken. A byte read,
// a drawing command with an unused mode code and an unused operation code pass through
// S_READ or S_FLUSH and raise out_valid and free the input once the output is free.
// After reset the block runs a clearing pass over the whole store during which
// in_stall stays high. Every command returns exactly one read_data transfer, zero for
// all commands except a read. in_stall does not depend on out_stall: the output register
// holds a waiting result while the next command runs, and a finished command waits in
// its final state, with in_stall high, until the output register is free.
module mono_page_framebuffer_fill
    import mpff_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int PAGES   = PAGES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] operation,
    input  wire logic [1:0] mode,
    input  wire logic [7:0] x_first,
    input  wire logic [7:0] x_second,
    input  wire logic [7:0] y_first,
    input  wire logic [7:0] y_second,
    input  wire logic [7:0] thickness,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      read_data
);

    localparam int DEPTH  = PAGES * COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SWEEP,
        S_FLUSH
    } state_t;

    // control registers
    state_t              state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          read_data_reg, read_data_next;
    logic                clr_result_reg, clr_result_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic                wr_valid_reg, wr_valid_next;

    // payload registers
    logic [7:0]          col_start_reg, row_start_reg;
    logic [8:0]          col_len_reg, row_len_reg;
    logic [1:0]          mode_reg;
    logic                rd_ok_reg;
    logic [ADDR_W-1:0]   wr_addr_reg;
    logic [7:0]          wr_mask_reg;
    logic [7:0]          mem_rdata_reg;

    // memory port controls
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [7:0]          mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    logic [7:0]          frame_store [DEPTH];

    logic                accept;
    logic                out_free;
    logic                sweep_last;
    logic [7:0]          sweep_mask;
    logic [7:0]          mod_byte;

    // command geometry decoded at transfer
    logic [7:0]          half_w;
    logic [7:0]          x_lo, x_hi, y_lo, y_hi;
    logic [7:0]          geo_col_start, geo_row_start;
    logic [8:0]          geo_col_len, geo_row_len;
    logic                geo_rd_ok;
    logic [ADDR_W-1:0]   rd_addr;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

    // line ends ordered, thickness centered on the line coordinate
    always_comb
    begin
        half_w = {1'b0, thickness[7:1]};
        x_lo   = (x_first < x_second) ? x_first : x_second;
        x_hi   = (x_first < x_second) ? x_second : x_first;
        y_lo   = (y_first < y_second) ? y_first : y_second;
        y_hi   = (y_first < y_second) ? y_second : y_first;
        case (operation)
            OP_VLINE:
            begin
                geo_col_start = x_first - half_w;
                geo_col_len   = {1'b0, thickness};
                geo_row_start = y_lo;
                geo_row_len   = {1'b0, y_hi} - {1'b0, y_lo};
            end
            OP_HLINE:
            begin
                geo_col_start = x_lo;
                geo_col_len   = {1'b0, x_hi} - {1'b0, x_lo} + 9'd1;
                geo_row_start = y_first - half_w;
                geo_row_len   = {1'b0, thickness};
            end
            default:
            begin
                geo_col_start = x_first;
                geo_col_len   = (x_first < x_second) ? {1'b0, x_second} - {1'b0, x_first}
                                                     : 9'd0;
                geo_row_start = y_first;
                geo_row_len   = (y_first < y_second) ? {1'b0, y_second} - {1'b0, y_first}
                                                     : 9'd0;
            end
        endcase
        geo_rd_ok = (y_first < 8'(PAGES)) && ({1'b0, x_first} < 9'(COLUMNS));
        rd_addr   = ADDR_W'(32'(y_first[PAGE_W-1:0]) * 32'(COLUMNS)
                            + 32'(x_first[COL_W-1:0]));
    end

    // pixel mask of the byte at the sweep position
    always_comb
    begin
        logic [7:0] x_val;
        logic [7:0] y_val;
        logic       col_hit;
        x_val   = 8'(col_reg);
        col_hit = {1'b0, 8'(x_val - col_start_reg)} < col_len_reg;
        for (int b = 0; b < PAGE_ROWS; b++)
        begin
            y_val         = 8'({page_reg, 3'(b)});
            sweep_mask[b] = col_hit && ({1'b0, 8'(y_val - row_start_reg)} < row_len_reg);
        end
    end

    assign sweep_last = (addr_reg == ADDR_W'(DEPTH - 1));

    // modify stage applied to the byte from the registered read port
    always_comb
    begin
        case (mode_reg)
            MODE_SET:    mod_byte = mem_rdata_reg | wr_mask_reg;
            MODE_CLEAR:  mod_byte = mem_rdata_reg & ~wr_mask_reg;
            MODE_INVERT: mod_byte = mem_rdata_reg ^ wr_mask_reg;
            default:     mod_byte = mem_rdata_reg;
        endcase
    end

    // sequencer next state and memory port control
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && out_stall;
        read_data_next  = read_data_reg;
        clr_result_next = clr_result_reg;
        addr_next       = addr_reg;
        col_next        = col_reg;
        page_next       = page_reg;
        wr_valid_next   = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = addr_reg;
        mem_we          = wr_valid_reg;
        mem_waddr       = wr_addr_reg;
        mem_wdata       = mod_byte;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = 8'h00;
                addr_next = addr_reg + ADDR_W'(1);
                if (sweep_last)
                begin
                    addr_next = '0;
                    if (clr_result_reg)
                    begin
                        clr_result_next = 1'b0;
                        state_next      = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    addr_next = '0;
                    col_next  = '0;
                    page_next = '0;
                    unique case (operation) inside
                        OP_RECT, OP_VLINE, OP_HLINE:
                        begin
                            if (mode inside {MODE_SET, MODE_CLEAR, MODE_INVERT})
                            begin
                                state_next = S_SWEEP;
                            end
                            else
                            begin
                                state_next = S_FLUSH;
                            end
                        end
                        OP_CLEAR:
                        begin
                            clr_result_next = 1'b1;
                            state_next      = S_CLEAR;
                        end
                        OP_READ:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = rd_addr;
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_FLUSH;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    read_data_next = rd_ok_reg ? mem_rdata_reg : 8'h00;
                    state_next     = S_IDLE;
                end
            end
            S_SWEEP:
            begin
                mem_re        = 1'b1;
                mem_raddr     = addr_reg;
                wr_valid_next = 1'b1;
                addr_next     = addr_reg + ADDR_W'(1);
                if (col_reg == COL_W'(COLUMNS - 1))
                begin
                    col_next  = '0;
                    page_next = page_reg + PAGE_W'(1);
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
                if (sweep_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    read_data_next = 8'h00;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            out_valid_reg  <= 1'b0;
            read_data_reg  <= 8'h00;
            clr_result_reg <= 1'b0;
            addr_reg       <= '0;
            col_reg        <= '0;
            page_reg       <= '0;
            wr_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            read_data_reg  <= read_data_next;
            clr_result_reg <= clr_result_next;
            addr_reg       <= addr_next;
            col_reg        <= col_next;
            page_reg       <= page_next;
            wr_valid_reg   <= wr_valid_next;
        end
    end

    // command payload and write stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_start_reg <= geo_col_start;
            col_len_reg   <= geo_col_len;
            row_start_reg <= geo_row_start;
            row_len_reg   <= geo_row_len;
            mode_reg      <= mode;
            rd_ok_reg     <= geo_rd_ok;
        end
        wr_addr_reg <= addr_reg;
        wr_mask_reg <= sweep_mask;
    end

    // display store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_store[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= frame_store[mem_raddr];
        end
    end

    // write stage is only live while sweeping or draining
    a_wr_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid_reg |-> (state_reg == S_SWEEP || state_reg == S_FLUSH))
        else $error("write stage active outside a sweep");

    // no transfer is taken while the store is being cleared
    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> in_stall)
        else $error("input taken during clearing pass");

    // the byte written back is the one read just before it
    a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP && wr_valid_reg) |-> (wr_addr_reg + ADDR_W'(1) == addr_reg))
        else $error("read-modify-write address out of order");

    // a command leaving the flush state delivers a zero result once the output is free
    a_sweep_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH && out_free) |=> (out_valid_reg && read_data_reg == 8'h00))
        else $error("sweep did not deliver its result");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(read_data_reg)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== dv/tb_mono_page_framebuffer_fill.sv =====
`timescale 1ns / 100ps
// tb_mono_page_framebuffer_fill: self-checking bench for the page framebuffer fill block
// depends on mpff_pkg and mono_page_framebuffer_fill; a scoreboard class predicts read_data

module tb_mono_page_framebuffer_fill
    import mpff_pkg::*;
();

    localparam int COLS         = COLUMNS_DEF;
    localparam int PAGE_COUNT   = PAGES_DEF;
    localparam int ROWS         = PAGE_COUNT * PAGE_ROWS;
    localparam int SWEEP_CYCLES = PAGE_COUNT * COLS + 2;
    localparam int TAIL_CYCLES  = 2 * SWEEP_CYCLES;
    localparam int LIMIT_CYCLES = 4000000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int MAX_REPORTS  = 10;

    // codes the package leaves unnamed
    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam logic [2:0] OP_UNUSED_MAX = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] mode;
        logic [7:0] x0;
        logic [7:0] x1;
        logic [7:0] y0;
        logic [7:0] y1;
        logic [7:0] thick;
    } fill_cmd_t;

    // frame store shadow and queue of expected read_data bytes
    class frame_scoreboard;
        bit [7:0]    pixels [PAGE_COUNT][COLS];
        bit [7:0]    expected_bytes [$];
        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned commands_seen;
        int unsigned reads_nonzero;
        int unsigned op_counts [8];

        function int unsigned pending();
            return expected_bytes.size();
        endfunction

        // one pixel update, clipped to the visible area
        function void touch(int x, int y, logic [1:0] m);
            bit [7:0] mask;
            if (x >= COLS || y >= ROWS)
                return;
            mask = 8'h01 << (y % PAGE_ROWS);
            case (m)
                MODE_SET:    pixels[y / PAGE_ROWS][x] |= mask;
                MODE_CLEAR:  pixels[y / PAGE_ROWS][x] &= ~mask;
                MODE_INVERT: pixels[y / PAGE_ROWS][x] ^= mask;
                default:     ;
            endcase
        endfunction

        // first coordinate of a centered band; (w-1)/2 for odd w equals w/2
        function bit [7:0] band_start(bit [7:0] centre, bit [7:0] w);
            return centre - (w >> 1);
        endfunction

        function void note_command(fill_cmd_t c);
            bit [7:0] lo;
            bit [7:0] hi;
            bit [7:0] s;
            bit [7:0] pos;
            bit [7:0] result;
            result = 8'h00;
            commands_seen++;
            op_counts[c.op]++;
            case (c.op)
                OP_RECT:
                begin
                    for (int i = c.x0; i < c.x1 && i < COLS; i++)
                        for (int j = c.y0; j < c.y1 && j < ROWS; j++)
                            touch(i, j, c.mode);
                end
                OP_VLINE:
                begin
                    lo = (c.y0 < c.y1) ? c.y0 : c.y1;
                    hi = (c.y0 < c.y1) ? c.y1 : c.y0;
                    s  = band_start(c.x0, c.thick);
                    for (int i = 0; i < c.thick; i++)
                    begin
                        pos = s + 8'(i);
                        for (int j = lo; j < hi && j < ROWS; j++)
                            touch(pos, j, c.mode);
                    end
                end
                OP_HLINE:
                begin
                    // inclusive end, so 255 must not wrap the loop
                    lo = (c.x0 < c.x1) ? c.x0 : c.x1;
                    hi = (c.x0 < c.x1) ? c.x1 : c.x0;
                    s  = band_start(c.y0, c.thick);
                    for (int i = 0; i < c.thick; i++)
                    begin
                        pos = s + 8'(i);
                        for (int j = lo; j <= hi && j < COLS; j++)
                            touch(j, pos, c.mode);
                    end
                end
                OP_CLEAR:
                begin
                    foreach (pixels[p, x])
                        pixels[p][x] = 8'h00;
                end
                OP_READ:
                begin
                    if (c.y0 < PAGE_COUNT && c.x0 < COLS)
                        result = pixels[c.y0][c.x0];
                    if (result != 8'h00)
                        reads_nonzero++;
                end
                default: ;
            endcase
            expected_bytes.push_back(result);
        endfunction

        function void check_result(logic [7:0] got);
            bit [7:0] want;
            results_seen++;
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected read_data transfer %02h, nothing outstanding", got);
                return;
            end
            want = expected_bytes.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("read_data mismatch on result %0d: expected %02h, got %02h",
                             results_seen, want, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [2:0]  operation = OP_READ;
    logic [1:0]  mode      = MODE_SET;
    logic [7:0]  x_first   = 8'h00;
    logic [7:0]  x_second  = 8'h00;
    logic [7:0]  y_first   = 8'h00;
    logic [7:0]  y_second  = 8'h00;
    logic [7:0]  thickness = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  read_data;

    logic        rx_hold        = 1'b0;
    int unsigned recv_stall_pct = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned cycle_count    = 0;

    frame_scoreboard board = new();

    mono_page_framebuffer_fill DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .mode      (mode),
        .x_first   (x_first),
        .x_second  (x_second),
        .y_first   (y_first),
        .y_second  (y_second),
        .thickness (thickness),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .read_data (read_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stall, random or held off
    always @(posedge clk)
    begin
        out_stall <= rx_hold || ($urandom_range(0, 99) < recv_stall_pct);
    end

    // monitor both channels at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_result(read_data);
            if (in_valid && !in_stall)
                board.note_command({operation, mode, x_first, x_second,
                                    y_first, y_second, thickness});
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, board.pending());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic fill_cmd_t fill_cmd(logic [2:0] op, logic [1:0] m, logic [7:0] x0,
                                           logic [7:0] x1, logic [7:0] y0, logic [7:0] y1,
                                           logic [7:0] w);
        fill_cmd_t c;
        c = '{op, m, x0, x1, y0, y1, w};
        return c;
    endfunction

    // mostly well-aimed commands, some pure noise
    function automatic fill_cmd_t random_command();
        fill_cmd_t   c;
        int unsigned pick;
        bit          near;
        logic [1:0]  draw_mode;
        pick      = $urandom_range(0, 99);
        near      = ($urandom_range(0, 3) != 0);
        draw_mode = ($urandom_range(0, 24) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
        c.op      = 3'($urandom_range(0, OP_UNUSED_MAX));
        c.mode    = 2'($urandom);
        c.x0      = 8'($urandom);
        c.x1      = 8'($urandom);
        c.y0      = 8'($urandom);
        c.y1      = 8'($urandom);
        c.thick   = 8'($urandom);
        if (pick < 30)
        begin
            c.op = OP_READ;
            c.x0 = 8'($urandom_range(0, COLS - 1));
            c.y0 = 8'($urandom_range(0, PAGE_COUNT - 1));
        end
        else if (pick < 35)
            c.op = OP_READ;
        else if (pick < 60)
        begin
            c.op   = OP_RECT;
            c.mode = draw_mode;
            if (near)
            begin
                c.x0 = 8'($urandom_range(0, 130));
                c.x1 = c.x0 + 8'($urandom_range(0, 40));
                c.y0 = 8'($urandom_range(0, 36));
                c.y1 = c.y0 + 8'($urandom_range(0, 20));
            end
        end
        else if (pick < 73)
        begin
            c.op   = OP_VLINE;
            c.mode = draw_mode;
            if (near)
            begin
                c.x0    = 8'($urandom_range(0, 135));
                c.y0    = 8'($urandom_range(0, 40));
                c.y1    = 8'($urandom_range(0, 40));
                c.thick = 8'($urandom_range(0, 12));
            end
        end
        else if (pick < 86)
        begin
            c.op   = OP_HLINE;
            c.mode = draw_mode;
            if (near)
            begin
                c.x0    = 8'($urandom_range(0, 135));
                c.x1    = 8'($urandom_range(0, 135));
                c.y0    = 8'($urandom_range(0, 40));
                c.thick = 8'($urandom_range(0, 12));
            end
        end
        else if (pick < 89)
            c.op = OP_CLEAR;
        else if (pick < 94)
            c.op = OP_READ + 3'($urandom_range(1, OP_UNUSED_MAX - OP_READ));
        return c;
    endfunction

    // offer one command and wait for its transfer; valid stays up afterwards
    task automatic send_command(input fill_cmd_t c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= c.op;
        mode      <= c.mode;
        x_first   <= c.x0;
        x_second  <= c.x1;
        y_first   <= c.y0;
        y_second  <= c.y1;
        thickness <= c.thick;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // let the monitor note the last transfer before looking at the queue
    task automatic wait_drained();
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic hold_receiver(input int unsigned cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        rx_hold <= 1'b0;
    endtask

    task automatic run_random(input int unsigned count, input int unsigned idle_pct,
                              input int unsigned stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct <= stall_pct;
        for (int n = 0; n < count; n++)
            send_command(random_command());
        in_valid <= 1'b0;
        wait_drained();
    endtask

    // stimulus
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, reversed ends, wrap, clipping, empty shapes
        send_command(fill_cmd(OP_READ,   MODE_SET,    8'd0,   8'd0,   8'd0,   8'd0,   8'd0));
        send_command(fill_cmd(OP_RECT,   MODE_SET,    8'd0,   8'd128, 8'd0,   8'd32,  8'd0));
        send_command(fill_cmd(OP_READ,   MODE_SET,    8'd127, 8'd0,   8'd3,   8'd0,   8'd0));
        send_command(fill_cmd(OP_RECT,   MODE_INVERT, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0));
        send_command(fill_cmd(OP_RECT,   MODE_SET,    8'd50,  8'd10,  8'd5,   8'd20,  8'd0));
        send_command(fill_cmd(OP_RECT,   MODE_SET,    8'd10,  8'd20,  8'd12,  8'd12,  8'd0));
        send_command(fill_cmd(OP_VLINE,  MODE_SET,    8'd64,  8'd0,   8'd30,  8'd2,   8'd4));
        send_command(fill_cmd(OP_VLINE,  MODE_INVERT, 8'd0,   8'd0,   8'd0,   8'd32,  8'd3));
        send_command(fill_cmd(OP_VLINE,  MODE_SET,    8'd100, 8'd0,   8'd0,   8'd32,  8'd0));
        send_command(fill_cmd(OP_HLINE,  MODE_CLEAR,  8'd255, 8'd100, 8'd16,  8'd0,   8'd255));
        send_command(fill_cmd(OP_HLINE,  MODE_SET,    8'd127, 8'd0,   8'd31,  8'd0,   8'd1));
        send_command(fill_cmd(OP_HLINE,  MODE_INVERT, 8'd5,   8'd5,   8'd0,   8'd0,   8'd2));
        send_command(fill_cmd(OP_READ,   MODE_SET,    8'd64,  8'd0,   8'd0,   8'd0,   8'd0));
        send_command(fill_cmd(OP_READ,   MODE_SET,    8'd0,   8'd0,   8'd3,   8'd0,   8'd0));
        send_command(fill_cmd(OP_READ,   MODE_SET,    8'd127, 8'd0,   8'd3,   8'd0,   8'd0));
        send_command(fill_cmd(OP_RECT,   MODE_UNUSED, 8'd0,   8'd128, 8'd0,   8'd32,  8'd0));
        send_command(fill_cmd(OP_READ,   MODE_SET,    8'd64,  8'd0,   8'd1,   8'd0,   8'd0));
        send_command(fill_cmd(OP_READ,   MODE_SET,    8'd128, 8'd0,   8'd0,   8'd0,   8'd0));
        send_command(fill_cmd(OP_READ,   MODE_SET,    8'd0,   8'd0,   8'd4,   8'd0,   8'd0));
        send_command(fill_cmd(OP_READ,   MODE_INVERT, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        for (int k = 1; k <= OP_UNUSED_MAX - OP_READ; k++)
            send_command(fill_cmd(OP_READ + 3'(k), MODE_SET, 8'd7, 8'd9, 8'd1, 8'd3, 8'd5));
        send_command(fill_cmd(OP_CLEAR,  MODE_UNUSED, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0));
        send_command(fill_cmd(OP_READ,   MODE_SET,    8'd127, 8'd0,   8'd3,   8'd0,   8'd0));
        send_command(fill_cmd(OP_VLINE,  MODE_SET,    8'd255, 8'd0,   8'd255, 8'd0,   8'd255));
        send_command(fill_cmd(OP_READ,   MODE_SET,    8'd10,  8'd0,   8'd2,   8'd0,   8'd0));
        in_valid <= 1'b0;
        wait_drained();

        // random, back to back
        run_random(250, 0, 0);

        // long receiver hold-off while commands keep coming
        recv_stall_pct <= 0;
        fork
            hold_receiver(HOLD_CYCLES);
            begin
                for (int n = 0; n < 12; n++)
                    send_command(random_command());
            end
        join
        in_valid <= 1'b0;
        wait_drained();

        run_random(250, 85, 0);
        run_random(250, 0, 85);
        run_random(250, 11, 11);

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d commands: %0d rect, %0d vertical, %0d horizontal, %0d clear,",
                 board.commands_seen, board.op_counts[OP_RECT], board.op_counts[OP_VLINE],
                 board.op_counts[OP_HLINE], board.op_counts[OP_CLEAR]);
        $display("%0d reads (%0d nonzero); %0d results checked, %0d mismatches, %0d cycles",
                 board.op_counts[OP_READ], board.reads_nonzero, board.results_seen,
                 board.mismatches, cycle_count);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
